### design/consistent_hash_ring_lookup_defines.svh
// ----------------------------------------------------------------------------
// Consistent hash ring lookup: assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_LOOKUP_DEFINES_SVH
`define CONSISTENT_HASH_RING_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a full property on every rising edge outside reset.
`define CHRL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition implies a consequent in the same cycle.
`define CHRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define CHRL_ASSERT(lbl, clk, rst_n, prop, msg)
`define CHRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/chrl_pkg.sv
// ----------------------------------------------------------------------------
// chrl_pkg
// Types, widths and codes shared by the ring lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package chrl_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 13;
  localparam int SLOT_W      = 12;
  localparam int POINT_W     = 32;
  localparam int SERVER_W    = 8;
  localparam int KEY_W       = 32;
  localparam int DIV_CNT_W   = $clog2(KEY_W);
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // Input item kinds
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Register map, indexed by paddr[2]
  typedef enum logic {
    REG_TABLE_COUNT,
    REG_DIST_MODE
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_DIV,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [POINT_W-1:0]  point;
    logic [SERVER_W-1:0] server;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // latch key and count of an accepted lookup
    logic mem_wr;    // write the accepted load into the table
    logic rd_mid;    // issue a probe read at the search midpoint
    logic cmp;       // narrow the search window from the probe data
    logic div_step;  // one restoring division step
    logic fetch;     // read the selected slot
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;  // effective count is zero (sampled on accept)
    logic modulo;    // modulo distribution selected (sampled on accept)
    logic lo_lt_hi;  // search window still open
    logic div_last;  // final division step
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

### design/chrl_ifs.sv
// ----------------------------------------------------------------------------
// chrl_in_if / chrl_out_if
// Valid/ready channels for request items and lookup results.
// ----------------------------------------------------------------------------
`default_nettype none

interface chrl_in_if import chrl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SLOT_W-1:0]   slot;
  logic [POINT_W-1:0]  point_value;
  logic [SERVER_W-1:0] server_number;
  logic [KEY_W-1:0]    key_hash;

  modport src (output valid, mode, slot, point_value, server_number, key_hash,
               input ready);
  modport snk (input valid, mode, slot, point_value, server_number, key_hash,
               output ready);
endinterface

interface chrl_out_if import chrl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SERVER_W-1:0] chosen_server;
  logic [SLOT_W-1:0]   chosen_slot;
  logic                empty_table;

  modport src (output valid, chosen_server, chosen_slot, empty_table,
               input ready);
  modport snk (input valid, chosen_server, chosen_slot, empty_table,
               output ready);
endinterface

`default_nettype wire

### design/chrl_ctrl.sv
// ----------------------------------------------------------------------------
// chrl_ctrl
// Sequencer for load, ring search and modulo lookup.
// ----------------------------------------------------------------------------
`default_nettype none
`include "consistent_hash_ring_lookup_defines.svh"

module chrl_ctrl import chrl_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_mode,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_mode == MODE_LOOKUP) begin
          if (st.cnt_zero) begin
            state_nxt = ST_DONE;
          end else if (st.modulo) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_SRCH:  state_nxt = st.lo_lt_hi ? ST_CMP : ST_FETCH;
      ST_CMP:   state_nxt = ST_SRCH;
      ST_DIV:   state_nxt = st.div_last ? ST_FETCH : ST_DIV;
      ST_FETCH: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = st.out_free ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.start    = in_valid && in_mode == MODE_LOOKUP;
        cmd.mem_wr   = in_valid && in_mode == MODE_LOAD;
      end
      ST_SRCH:  cmd.rd_mid   = st.lo_lt_hi;
      ST_CMP:   cmd.cmp      = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FETCH: cmd.fetch    = 1'b1;
      ST_DONE:  cmd.out_load = st.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  `CHRL_ASSERT_IMP(a_out_load_free, clk, rst_n, cmd.out_load, st.out_free,
                   "result loaded while output register is held")
  `CHRL_ASSERT(a_div_exit, clk, rst_n,
               (state_r == ST_DIV && st.div_last) |=> (state_r == ST_FETCH),
               "division did not end in a slot fetch")
  `CHRL_ASSERT(a_empty_skip, clk, rst_n,
               (cmd.start && st.cnt_zero) |=> (state_r == ST_DONE),
               "empty-table lookup did not skip to the result")

endmodule

`default_nettype wire

### design/chrl_dpath.sv
// ----------------------------------------------------------------------------
// chrl_dpath
// Ring table memory, search window, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "consistent_hash_ring_lookup_defines.svh"

module chrl_dpath import chrl_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output status_t                  st,
  input  wire logic [CNT_W-1:0]    table_count,
  input  wire logic                dist_mode,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [POINT_W-1:0]  in_point,
  input  wire logic [SERVER_W-1:0] in_server,
  input  wire logic [KEY_W-1:0]    in_key,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SERVER_W-1:0]      out_server,
  output logic [SLOT_W-1:0]        out_slot,
  output logic                     out_empty
);

  entry_t               mem [TABLE_DEPTH];
  entry_t               rd_q;

  logic [CNT_W-1:0]     eff_cnt;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     lo_r;
  logic [CNT_W-1:0]     hi_r;
  logic [CNT_W-1:0]     mid;
  logic [ADDR_W-1:0]    mid_r;
  logic [KEY_W-1:0]     key_r;
  logic [KEY_W-1:0]     shift_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W:0]       trial;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 modulo_r;
  logic                 empty_r;
  logic [ADDR_W-1:0]    sel;
  logic [ADDR_W-1:0]    sel_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_ok;
  logic                 out_valid_r;

  // Saturate the programmed count at the table depth
  assign eff_cnt = (32'(table_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : table_count;

  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign trial = {rem_r, shift_r[KEY_W-1]};
  assign sel   = modulo_r ? rem_r[ADDR_W-1:0]
                          : ((lo_r >= n_r) ? '0 : lo_r[ADDR_W-1:0]);
  assign rd_addr = cmd.rd_mid ? mid[ADDR_W-1:0] : sel;
  assign wr_ok   = 32'(in_slot) < TABLE_DEPTH;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) begin
      mem[in_slot[ADDR_W-1:0]] <= '{point: in_point, server: in_server};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_mid || cmd.fetch) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Search window, divider and selected slot
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r    <= in_key;
      shift_r  <= in_key;
      n_r      <= eff_cnt;
      lo_r     <= '0;
      hi_r     <= eff_cnt;
      rem_r    <= '0;
      cnt_r    <= '0;
      modulo_r <= dist_mode;
      empty_r  <= (eff_cnt == '0);
    end else begin
      if (cmd.rd_mid) begin
        mid_r <= mid[ADDR_W-1:0];
      end
      if (cmd.cmp) begin
        if (rd_q.point < key_r) begin
          lo_r <= {1'b0, mid_r} + CNT_W'(1);
        end else begin
          hi_r <= {1'b0, mid_r};
        end
      end
      if (cmd.div_step) begin
        shift_r <= {shift_r[KEY_W-2:0], 1'b0};
        cnt_r   <= cnt_r + DIV_CNT_W'(1);
        if (trial >= {1'b0, n_r}) begin
          rem_r <= CNT_W'(trial - {1'b0, n_r});
        end else begin
          rem_r <= trial[CNT_W-1:0];
        end
      end
    end
    if (cmd.fetch) begin
      sel_r <= sel;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_server <= empty_r ? '0 : rd_q.server;
      out_slot   <= empty_r ? '0 : SLOT_W'(sel_r);
      out_empty  <= empty_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign st.cnt_zero = (eff_cnt == '0);
  assign st.modulo   = dist_mode;
  assign st.lo_lt_hi = lo_r < hi_r;
  assign st.div_last = (cnt_r == DIV_CNT_W'(KEY_W - 1));
  assign st.out_free = !out_valid_r || out_ready;

  `CHRL_ASSERT(a_window_order, clk, rst_n, cmd.cmp |=> (lo_r <= hi_r && hi_r <= n_r),
               "search window out of order")
  `CHRL_ASSERT_IMP(a_rem_range, clk, rst_n, cmd.div_step, rem_r < n_r,
                   "partial remainder not below the entry count")
  `CHRL_ASSERT(a_empty_result, clk, rst_n,
               (cmd.out_load && empty_r) |=> (out_server == '0 && out_empty),
               "empty lookup gave a nonzero server")

endmodule

`default_nettype wire

### design/consistent_hash_ring_lookup.sv
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup
// Ketama-style ring table with binary search or modulo slot selection.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake       payload
//   in_chan   sink       valid/ready     mode, slot, point_value,
//                                        server_number, key_hash
//   out_chan  source     valid/ready     chosen_server, chosen_slot,
//                                        empty_table
//   apb       slave      psel/penable    table_count (0x0), dist_mode (0x4)
//
// A load request writes its slot at acceptance.
// A ring lookup makes up to 13 probes at 4096 entries; each probe is one
// read of the single table read port plus a compare.
// A modulo lookup runs a restoring divider at one key bit per cycle.
// An empty-table lookup goes straight to the result. Reset needs no clearing pass.
// A stalled result waits in the output register while the next request is
// taken; a second result then holds the sequencer until the first leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module consistent_hash_ring_lookup import chrl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  chrl_in_if.snk                     in_chan,
  chrl_out_if.src                    out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // Configuration registers
  logic [CNT_W-1:0] table_count_r;
  logic             dist_mode_r;
  reg_idx_t         reg_idx;
  logic             cfg_wr;

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_count_r <= '0;
      dist_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TABLE_COUNT: table_count_r <= pwdata[CNT_W-1:0];
        REG_DIST_MODE:   dist_mode_r   <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TABLE_COUNT: prdata = APB_DATA_W'(table_count_r);
      REG_DIST_MODE:   prdata = APB_DATA_W'(dist_mode_r);
    endcase
  end

  // Sequencer: accept a request only when idle
  chrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_mode  (in_chan.mode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign in_chan.ready = in_ready;

  // Table, search window, divider and result register
  chrl_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .table_count (table_count_r),
    .dist_mode   (dist_mode_r),
    .in_slot     (in_chan.slot),
    .in_point    (in_chan.point_value),
    .in_server   (in_chan.server_number),
    .in_key      (in_chan.key_hash),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_server  (out_chan.chosen_server),
    .out_slot    (out_chan.chosen_slot),
    .out_empty   (out_chan.empty_table)
  );

endmodule

`default_nettype wire
